### src/alpha_fade_ramp_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// Alpha fade ramp generator assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef ALPHA_FADE_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define ALPHA_FADE_RAMP_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFRG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/afrg_pkg.sv
// ----------------------------------------------------------------------------
// Alpha fade ramp generator package
// Types, codes and constants shared by the ramp generator modules.
// ----------------------------------------------------------------------------
package afrg_pkg;

    localparam int LEVEL_W  = 17;
    localparam int TARGET_W = 18;
    localparam int STEP_W   = 16;
    localparam int TIME_W   = 16;
    localparam int DELAY_W  = 24;
    localparam int SPEED_W  = 32;
    localparam int CMD_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W   = 48;
    localparam int DIVD_W   = 26;

    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = 26;
    localparam int CNT_W     = 5;

    localparam logic [LEVEL_W-1:0]         LEVEL_ONE   = 17'd65536;
    localparam logic signed [TARGET_W-1:0] TARGET_NONE = -18'sd131072;
    localparam logic signed [SPEED_W-1:0]  ACCEL_MIN     = 32'sd656;
    localparam logic signed [SPEED_W-1:0]  ACCEL_MIN_NEG = -32'sd656;
    localparam logic signed [SPEED_W-1:0]  SPEED_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SPEED_W-1:0]  SPEED_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ACCEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTORE      = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_FADE      = 3'd1,
        CMD_RESET     = 3'd2,
        CMD_ATTACH    = 3'd3,
        CMD_SET_ALPHA = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_SPD,
        S_MOV,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic                       start;
        t_alu_op                    op;
        logic signed [SPEED_W-1:0]  mcand;
        logic [STEP_W-1:0]          mplier;
        logic [DIVD_W-1:0]          dividend;
    } t_alu_req;

    typedef struct packed {
        logic                      done;
        logic                      busy;
        logic signed [PROD_W-1:0]  result;
    } t_alu_rsp;

endpackage

### src/afrg_if.sv
// ----------------------------------------------------------------------------
// Alpha fade ramp generator channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface afrg_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [afrg_pkg::CMD_W-1:0]              cmd;
    logic [afrg_pkg::STEP_W-1:0]             step;
    logic signed [afrg_pkg::TARGET_W-1:0]    fade_target;
    logic [afrg_pkg::TIME_W-1:0]             fade_time;
    logic [afrg_pkg::LEVEL_W-1:0]            new_alpha;

    modport source (output valid, cmd, step, fade_target, fade_time, new_alpha,
                    input ready);
    modport sink   (input valid, cmd, step, fade_target, fade_time, new_alpha,
                    output ready);
endinterface

interface afrg_out_if;
    logic                          valid;
    logic                          ready;
    logic [afrg_pkg::LEVEL_W-1:0]  level;
    logic                          animating;

    modport source (output valid, level, animating, input ready);
    modport sink   (input valid, level, animating, output ready);
endinterface

interface afrg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [afrg_pkg::CFG_IDX_W-1:0]   index;
    logic [afrg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/alpha_fade_ramp_generator_unit.sv
// Reset, attach, set alpha, zero-time fades and ticks that only count delay or sit on the
// target go straight from execution to the result register; a tick also runs the 16-step
// multiplier, twice with acceleration, and a fade runs the 26-step divider.
// One command is in flight, so a new command is accepted only once the last result is
// registered; a held result keeps the next command in its last state.
// Synchronous active-low reset restores all start values and clears the level.
// ----------------------------------------------------------------------------
// Alpha fade ramp generator top level
// Command sequencer, ramp state and result register around the shared unit.
// ----------------------------------------------------------------------------
`include "alpha_fade_ramp_generator_unit_defines.svh"

module alpha_fade_ramp_generator_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    afrg_cfg_if.sink i_cfg,
    afrg_in_if.sink  i_in,
    afrg_out_if.source o_out
);
    import afrg_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd,   n_cmd;
    logic [STEP_W-1:0]          r_step,   n_step;
    logic signed [TARGET_W-1:0] r_dest,   n_dest;
    logic [TIME_W-1:0]          r_time,   n_time;
    logic [LEVEL_W-1:0]         r_na,     n_na;

    logic [LEVEL_W-1:0]         r_level,  n_level;
    logic signed [SPEED_W-1:0]  r_speed,  n_speed;
    logic signed [SPEED_W-1:0]  r_accel,  n_accel;
    logic [DELAY_W-1:0]         r_delay,  n_delay;
    logic signed [TARGET_W-1:0] r_target, n_target;
    logic [LEVEL_W-1:0]         r_saved,  n_saved;
    logic                       r_saved_vld, n_saved_vld;
    logic                       r_neg,    n_neg;

    logic signed [SPEED_W-1:0]  r_st_speed,  n_st_speed;
    logic signed [SPEED_W-1:0]  r_st_accel,  n_st_accel;
    logic [DELAY_W-1:0]         r_st_delay,  n_st_delay;
    logic signed [TARGET_W-1:0] r_st_target, n_st_target;
    logic                       r_restore,   n_restore;

    logic                       r_out_vld,   n_out_vld;
    logic [LEVEL_W-1:0]         r_out_level, n_out_level;
    logic                       r_out_anim,  n_out_anim;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic [18:0]  diff;
    logic [18:0]  mag;
    logic [SPEED_W-1:0] delta;
    logic [32:0]  spd_sum;
    logic [33:0]  nxt, tgt34, dn, dp;
    logic [SPEED_W-1:0] quot;

    logic in_take;
    logic alu_wait;

    afrg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.level     = r_out_level;
    assign o_out.animating = r_out_anim;

    assign in_take  = i_in.valid && i_in.ready;
    assign alu_wait = (r_state == S_ACC) || (r_state == S_MOV) || (r_state == S_DIV);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_step      = r_step;
        n_dest      = r_dest;
        n_time      = r_time;
        n_na        = r_na;
        n_level     = r_level;
        n_speed     = r_speed;
        n_accel     = r_accel;
        n_delay     = r_delay;
        n_target    = r_target;
        n_saved     = r_saved;
        n_saved_vld = r_saved_vld;
        n_neg       = r_neg;
        n_st_speed  = r_st_speed;
        n_st_accel  = r_st_accel;
        n_st_delay  = r_st_delay;
        n_st_target = r_st_target;
        n_restore   = r_restore;
        n_out_vld   = r_out_vld;
        n_out_level = r_out_level;
        n_out_anim  = r_out_anim;

        alu_req.start    = 1'b0;
        alu_req.op       = ALU_MUL;
        alu_req.mcand    = r_speed;
        alu_req.mplier   = r_step;
        alu_req.dividend = '0;

        diff    = {r_dest[TARGET_W-1], r_dest} - {2'b00, r_level};
        mag     = diff[18] ? (~diff + 19'd1) : diff;
        delta   = alu_rsp.result[PROD_W-1:16];
        spd_sum = {r_speed[SPEED_W-1], r_speed} + {delta[SPEED_W-1], delta};
        nxt     = {17'b0, r_level} + {{2{delta[SPEED_W-1]}}, delta};
        tgt34   = {{16{r_target[TARGET_W-1]}}, r_target};
        dn      = tgt34 - nxt;
        dp      = tgt34 - {17'b0, r_level};
        quot    = {6'b0, alu_rsp.result[DIVD_W-1:0]};

        // Writes must arrive only while idle; the block does not enforce it, and the sequencer wins.
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_SPEED: begin
                    n_st_speed = $signed(i_cfg.data);
                    n_speed    = $signed(i_cfg.data);
                end
                CFG_START_ACCEL: begin
                    n_st_accel = $signed(i_cfg.data);
                    n_accel    = $signed(i_cfg.data);
                end
                CFG_START_DELAY: begin
                    n_st_delay = i_cfg.data[DELAY_W-1:0];
                    n_delay    = i_cfg.data[DELAY_W-1:0];
                end
                CFG_START_TARGET: begin
                    n_st_target = $signed(i_cfg.data[TARGET_W-1:0]);
                    n_target    = $signed(i_cfg.data[TARGET_W-1:0]);
                end
                CFG_RESTORE: begin
                    n_restore = i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = t_cmd'(i_in.cmd);
                    n_step  = i_in.step;
                    n_dest  = i_in.fade_target;
                    n_time  = i_in.fade_time;
                    n_na    = i_in.new_alpha;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_TICK: begin
                        if (r_delay != '0) begin
                            n_delay = (r_delay > {8'b0, r_step})
                                    ? r_delay - {8'b0, r_step} : '0;
                        end else if ({1'b0, r_level} == r_target) begin
                            n_state = S_DONE;
                        end else if (r_accel >= ACCEL_MIN || r_accel <= ACCEL_MIN_NEG) begin
                            alu_req.start = 1'b1;
                            alu_req.mcand = r_accel;
                            n_state       = S_ACC;
                        end else begin
                            n_state = S_SPD;
                        end
                    end
                    CMD_FADE: begin
                        n_target = r_dest;
                        n_accel  = '0;
                        n_delay  = '0;
                        if (r_time == '0) begin
                            if (diff == '0) begin
                                n_speed = '0;
                            end else begin
                                n_speed = diff[18] ? SPEED_MIN : SPEED_MAX;
                            end
                        end else begin
                            n_neg            = diff[18];
                            alu_req.start    = 1'b1;
                            alu_req.op       = ALU_DIV;
                            alu_req.mplier   = r_time;
                            alu_req.dividend = {mag[17:0], 8'b0};
                            n_state          = S_DIV;
                        end
                    end
                    CMD_RESET: begin
                        if (r_restore) begin
                            n_accel  = r_st_accel;
                            n_speed  = r_st_speed;
                            n_delay  = r_st_delay;
                            n_target = r_st_target;
                        end
                    end
                    CMD_ATTACH: begin
                        if (!r_saved_vld) begin
                            n_saved     = r_level;
                            n_saved_vld = 1'b1;
                        end else begin
                            n_level = r_saved;
                        end
                    end
                    CMD_SET_ALPHA: begin
                        n_level = (r_na > LEVEL_ONE) ? LEVEL_ONE : r_na;
                    end
                    default: begin
                    end
                endcase
            end
            S_ACC: begin
                if (alu_rsp.done) begin
                    if (spd_sum[32] != spd_sum[31]) begin
                        n_speed = spd_sum[32] ? SPEED_MIN : SPEED_MAX;
                    end else begin
                        n_speed = $signed(spd_sum[31:0]);
                    end
                    n_state = S_SPD;
                end
            end
            S_SPD: begin
                alu_req.start = 1'b1;
                n_state       = S_MOV;
            end
            S_MOV: begin
                if (alu_rsp.done) begin
                    // Crossing or landing on the target snaps the level onto it.
                    if (r_target != TARGET_NONE &&
                        ((dn[33] != dp[33]) || ((dn == '0) != (dp == '0)))) begin
                        nxt = tgt34;
                    end
                    if (nxt[33]) begin
                        n_level = '0;
                    end else if (nxt > {17'b0, LEVEL_ONE}) begin
                        n_level = LEVEL_ONE;
                    end else begin
                        n_level = nxt[LEVEL_W-1:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (alu_rsp.done) begin
                    n_speed = r_neg ? $signed(~quot + 32'd1) : $signed(quot);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_level = r_level;
                    n_out_anim  = ({1'b0, r_level} != r_target);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_speed     <= '0;
            r_accel     <= '0;
            r_delay     <= '0;
            r_target    <= TARGET_NONE;
            r_saved     <= '0;
            r_saved_vld <= 1'b0;
            r_st_speed  <= '0;
            r_st_accel  <= '0;
            r_st_delay  <= '0;
            r_st_target <= TARGET_NONE;
            r_restore   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_speed     <= n_speed;
            r_accel     <= n_accel;
            r_delay     <= n_delay;
            r_target    <= n_target;
            r_saved     <= n_saved;
            r_saved_vld <= n_saved_vld;
            r_st_speed  <= n_st_speed;
            r_st_accel  <= n_st_accel;
            r_st_delay  <= n_st_delay;
            r_st_target <= n_st_target;
            r_restore   <= n_restore;
            r_out_vld   <= n_out_vld;
        end
        r_cmd       <= n_cmd;
        r_step      <= n_step;
        r_dest      <= n_dest;
        r_time      <= n_time;
        r_na        <= n_na;
        r_neg       <= n_neg;
        r_out_level <= n_out_level;
        r_out_anim  <= n_out_anim;
    end

    `AFRG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_take, r_state != S_IDLE, "stayed idle")
    `AFRG_ASSERT_IMP(a_level_range, i_clk, i_rst_n, 1'b1, r_level <= LEVEL_ONE, "level above one")
    `AFRG_ASSERT_IMP(a_done_wait, i_clk, i_rst_n, alu_rsp.done, alu_wait, "unit done unexpectedly")

endmodule

### src/afrg_alu.sv
// ----------------------------------------------------------------------------
// Alpha fade ramp generator shared arithmetic unit
// Radix-2 shift-add multiplier and restoring divider on one 33-bit adder.
// ----------------------------------------------------------------------------
`include "alpha_fade_ramp_generator_unit_defines.svh"

module afrg_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afrg_pkg::t_alu_req  i_req,
    output afrg_pkg::t_alu_rsp  o_rsp
);
    import afrg_pkg::*;

    localparam int P_W = PROD_W + 1;

    logic [P_W-1:0]  r_p,    n_p;
    logic [32:0]     r_a,    n_a;
    t_alu_op         r_op,   n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    logic [32:0] opa, opb, sum;
    logic        cin;
    logic [16:0] rsh;
    logic [32:0] hi;
    logic        last;

    always_comb begin
        // Remainder sits in r_p[42:26], quotient bits in r_p[25:0].
        rsh = {r_p[41:26], r_p[25]};
        if (r_op == ALU_MUL) begin
            opa = r_p[P_W-1:STEP_W];
            opb = r_a;
            cin = 1'b0;
        end else begin
            opa = {16'b0, rsh};
            opb = ~r_a;
            cin = 1'b1;
        end
        sum = opa + opb + {32'b0, cin};
    end

    always_comb begin
        n_p    = r_p;
        n_a    = r_a;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        hi     = r_p[P_W-1:STEP_W];
        last   = (r_op == ALU_MUL) ? (r_cnt == CNT_W'(MUL_STEPS - 1))
                                   : (r_cnt == CNT_W'(DIV_STEPS - 1));
        if (i_req.start) begin
            n_op   = i_req.op;
            n_cnt  = '0;
            n_busy = 1'b1;
            if (i_req.op == ALU_MUL) begin
                n_p = {33'b0, i_req.mplier};
                n_a = {i_req.mcand[SPEED_W-1], i_req.mcand};
            end else begin
                n_p = {23'b0, i_req.dividend};
                n_a = {17'b0, i_req.mplier};
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                if (r_p[0]) begin
                    hi = sum;
                end
                n_p = {hi[32], hi, r_p[STEP_W-1:1]};
            end else if (!sum[32]) begin
                n_p = {6'b0, sum[16:0], r_p[24:0], 1'b1};
            end else begin
                n_p = {6'b0, rsh, r_p[24:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_p <= n_p;
        r_a <= n_a;
    end

    always_comb begin
        o_rsp.done   = r_done;
        o_rsp.busy   = r_busy;
        o_rsp.result = (r_op == ALU_MUL) ? $signed(r_p[PROD_W-1:0])
                                         : $signed({22'b0, r_p[DIVD_W-1:0]});
    end

    `AFRG_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, i_req.start, !r_busy, "start while busy")
    `AFRG_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy && !r_done, "no busy")
    `AFRG_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")

endmodule

### bench/tb_alpha_fade_ramp_generator_unit.sv
// ----------------------------------------------------------------------------
// Alpha fade ramp generator testbench
// Drives command and register transactions into the ramp generator, predicts
// every result from a behavioral copy of the ramp state, and compares each
// returned level and animating flag in order under random flow control.
// ----------------------------------------------------------------------------
module tb_alpha_fade_ramp_generator_unit;
    import afrg_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1520;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    localparam logic [CMD_W-1:0]     CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]           cmd;
        logic [STEP_W-1:0]          step;
        logic signed [TARGET_W-1:0] fade_target;
        logic [TIME_W-1:0]          fade_time;
        logic [LEVEL_W-1:0]         new_alpha;
    } t_ramp_cmd;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               animating;
    } t_ramp_result;

    logic clk;
    logic rst_n;

    afrg_cfg_if cfg_bus();
    afrg_in_if  cmd_bus();
    afrg_out_if res_bus();

    alpha_fade_ramp_generator_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (cmd_bus),
        .o_out   (res_bus)
    );

    // Predicted ramp state and start values.
    logic [LEVEL_W-1:0]         level_now;
    logic signed [SPEED_W-1:0]  speed_now;
    logic signed [SPEED_W-1:0]  accel_now;
    logic [DELAY_W-1:0]         delay_now;
    logic signed [TARGET_W-1:0] tgt_now;
    logic [LEVEL_W-1:0]         saved_now;
    logic                       saved_ok;
    logic signed [SPEED_W-1:0]  start_speed;
    logic signed [SPEED_W-1:0]  start_accel;
    logic [DELAY_W-1:0]         start_delay;
    logic signed [TARGET_W-1:0] start_target;
    logic                       restore_now;

    t_ramp_result expected_levels[$];
    int           items_sent;
    int           error_count;
    int           cycle_count;
    int           hold_requests;
    bit           no_idle;

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    function automatic int sign_of(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat_speed(input longint v);
        if (v > longint'(SPEED_MAX)) return SPEED_MAX;
        if (v < longint'(SPEED_MIN)) return SPEED_MIN;
        return SPEED_W'(v);
    endfunction

    function automatic logic [SPEED_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return SPEED_MAX;
            1: return SPEED_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? ACCEL_MIN : ACCEL_MIN_NEG;
            4: return $urandom_range(0, 1) ? ACCEL_MIN - 1 : ACCEL_MIN_NEG + 1;
            5, 6, 7: return SPEED_W'($urandom_range(0, 2097152)) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return STEP_W'($urandom());
            default: return STEP_W'($urandom_range(256, 4096));
        endcase
    endfunction

    function automatic t_ramp_cmd noise_item();
        t_ramp_cmd it;
        it.cmd         = CMD_W'($urandom_range(0, 7));
        it.step        = STEP_W'($urandom());
        it.fade_target = TARGET_W'($urandom());
        it.fade_time   = TIME_W'($urandom());
        it.new_alpha   = LEVEL_W'($urandom());
        return it;
    endfunction

    function automatic t_ramp_cmd make_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [STEP_W-1:0] step,
                                           input logic signed [TARGET_W-1:0] dest,
                                           input logic [TIME_W-1:0] dur,
                                           input logic [LEVEL_W-1:0] alpha);
        t_ramp_cmd it;
        it.cmd         = cmd;
        it.step        = step;
        it.fade_target = dest;
        it.fade_time   = dur;
        it.new_alpha   = alpha;
        return it;
    endfunction

    // Applies one command to the predicted state and returns the result it gives.
    function automatic t_ramp_result advance_ramp(input t_ramp_cmd it);
        t_ramp_result res;
        longint prev_lvl;
        longint next_lvl;
        longint diff;
        longint mag;
        longint tgt;
        tgt = longint'(tgt_now);
        case (it.cmd)
            CMD_TICK: begin
                if (delay_now != '0) begin
                    delay_now = (delay_now > it.step) ? delay_now - it.step : '0;
                end else if (longint'(level_now) != tgt) begin
                    if (accel_now >= ACCEL_MIN || accel_now <= ACCEL_MIN_NEG) begin
                        speed_now = sat_speed(longint'(speed_now)
                            + ((longint'(accel_now) * longint'(it.step)) >>> 16));
                    end
                    prev_lvl = longint'(level_now);
                    next_lvl = prev_lvl + ((longint'(speed_now) * longint'(it.step)) >>> 16);
                    // Crossing or landing on the target snaps to it.
                    if (tgt_now != TARGET_NONE
                        && sign_of(tgt - next_lvl) != sign_of(tgt - prev_lvl)) begin
                        next_lvl = tgt;
                    end
                    if (next_lvl < 0) next_lvl = 0;
                    if (next_lvl > longint'(LEVEL_ONE)) next_lvl = longint'(LEVEL_ONE);
                    level_now = LEVEL_W'(next_lvl);
                end
            end
            CMD_FADE: begin
                tgt_now = it.fade_target;
                diff = longint'(it.fade_target) - longint'(level_now);
                if (it.fade_time == '0) begin
                    speed_now = (diff > 0) ? SPEED_MAX : ((diff < 0) ? SPEED_MIN : '0);
                end else begin
                    mag = ((diff < 0) ? -diff : diff) * 256 / longint'(it.fade_time);
                    speed_now = sat_speed((diff < 0) ? -mag : mag);
                end
                accel_now = '0;
                delay_now = '0;
            end
            CMD_RESET: begin
                if (restore_now) begin
                    speed_now = start_speed;
                    accel_now = start_accel;
                    delay_now = start_delay;
                    tgt_now   = start_target;
                end
            end
            CMD_ATTACH: begin
                if (!saved_ok) begin
                    saved_now = level_now;
                    saved_ok  = 1'b1;
                end else begin
                    level_now = saved_now;
                end
            end
            CMD_SET_ALPHA: begin
                level_now = (it.new_alpha > LEVEL_ONE) ? LEVEL_ONE : it.new_alpha;
            end
            default: ;
        endcase
        res.level     = level_now;
        res.animating = (longint'(level_now) != longint'(tgt_now));
        return res;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR: %s", what);
    endtask

    // Valid stays high after acceptance; the next send or a drain decides.
    task automatic send_cmd(input t_ramp_cmd it);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30) gap = pick_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.cmd         <= it.cmd;
        cmd_bus.step        <= it.step;
        cmd_bus.fade_target <= it.fade_target;
        cmd_bus.fade_time   <= it.fade_time;
        cmd_bus.new_alpha   <= it.new_alpha;
        do @(posedge clk); while (!cmd_bus.ready);
        expected_levels.push_back(advance_ramp(it));
        if (it.cmd <= CMD_SET_ALPHA) items_sent++;
    endtask

    task automatic send_ticks(input int count);
        t_ramp_cmd it;
        repeat (count) begin
            it      = noise_item();
            it.cmd  = CMD_TICK;
            it.step = pick_step();
            send_cmd(it);
        end
    endtask

    task automatic wait_drain();
        cmd_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_levels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_START_SPEED: begin
                start_speed = data;
                speed_now   = data;
            end
            CFG_START_ACCEL: begin
                start_accel = data;
                accel_now   = data;
            end
            CFG_START_DELAY: begin
                start_delay = data[DELAY_W-1:0];
                delay_now   = data[DELAY_W-1:0];
            end
            CFG_START_TARGET: begin
                start_target = data[TARGET_W-1:0];
                tgt_now      = data[TARGET_W-1:0];
            end
            CFG_RESTORE: restore_now = data[0];
            default: ;
        endcase
    endtask

    // Upper data bits beyond each register's width carry random junk.
    task automatic apply_setting(input logic [SPEED_W-1:0] speed,
                                 input logic [SPEED_W-1:0] accel,
                                 input logic [DELAY_W-1:0] delay,
                                 input logic signed [TARGET_W-1:0] target,
                                 input logic restore);
        write_reg(CFG_START_SPEED, speed);
        write_reg(CFG_START_ACCEL, accel);
        write_reg(CFG_START_DELAY, {8'($urandom()), delay});
        write_reg(CFG_START_TARGET, {14'($urandom()), target});
        write_reg(CFG_RESTORE, {31'($urandom()), restore});
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), $urandom());
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_level_commands();
        send_cmd(make_cmd(CMD_TICK, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, LEVEL_ONE));
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, '1));
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_ATTACH, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, 17'd12345));
        send_cmd(make_cmd(CMD_ATTACH, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_UNUSED_LO, '1, '1, '1, '1));
        send_cmd(make_cmd(CMD_UNUSED_HI, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_RESET, '0, '0, '0, '0));
    endtask

    task automatic test_fade_commands();
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, 17'd32768));
        // Zero fade time saturates the speed in the direction of the target.
        send_cmd(make_cmd(CMD_FADE, '0, 18'sd65536, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_FADE, '0, 18'sd0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, 16'd1, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_FADE, '0, 18'sd0, '0, '0));
        // An unreachable target never snaps, so the level runs into the clamp.
        send_cmd(make_cmd(CMD_FADE, '0, TARGET_NONE, 16'd1, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_FADE, '0, 18'sd131071, '1, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
    endtask

    task automatic test_start_values();
        wait_drain();
        apply_setting(SPEED_MAX, SPEED_MAX, '1, 18'sd65536, 1'b1);
        send_cmd(make_cmd(CMD_RESET, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_FADE, '0, 18'sd65536, '0, '0));
        wait_drain();
        apply_setting(32'd0, ACCEL_MIN, '0, 18'sd40000, 1'b1);
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        wait_drain();
        apply_setting(SPEED_MIN, ACCEL_MIN - 1, '0, TARGET_NONE, 1'b0);
        send_cmd(make_cmd(CMD_SET_ALPHA, '0, '0, '0, LEVEL_ONE));
        send_cmd(make_cmd(CMD_TICK, 16'd1, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        wait_drain();
        apply_setting(32'd1000, ACCEL_MIN_NEG, 24'd100, 18'sd131071, 1'b1);
        send_cmd(make_cmd(CMD_TICK, 16'd50, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '1, '0, '0, '0));
        send_cmd(make_cmd(CMD_RESET, '0, '0, '0, '0));
    endtask

    task automatic test_random_ramps();
        int        phase;
        int        phase_end;
        int        kind;
        t_ramp_cmd it;
        logic [DELAY_W-1:0]         dly;
        logic signed [TARGET_W-1:0] tgt;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_drain();
            case (phase)
                0: apply_setting(SPEED_MAX, SPEED_MAX, '0, 18'sd65536, 1'b1);
                1: apply_setting(SPEED_MIN, SPEED_MIN, '0, TARGET_NONE, 1'b1);
                2: apply_setting('0, '0, '0, 18'sd131071, 1'b0);
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: dly = '0;
                        5, 6, 7, 8: dly = DELAY_W'($urandom_range(1, 200000));
                        default: dly = DELAY_W'($urandom());
                    endcase
                    case ($urandom_range(0, 9))
                        0: tgt = TARGET_NONE;
                        1: tgt = TARGET_W'($urandom());
                        default: tgt = TARGET_W'($urandom_range(0, 65536));
                    endcase
                    apply_setting(pick_rate(), pick_rate(), dly, tgt,
                                  $urandom_range(0, 3) != 0);
                end
            endcase
            no_idle   = (phase % 4 == 3);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    if ($urandom_range(0, 1)) begin
                        it           = noise_item();
                        it.cmd       = CMD_SET_ALPHA;
                        it.new_alpha = LEVEL_W'($urandom_range(0, 65536));
                        send_cmd(it);
                    end
                    it     = noise_item();
                    it.cmd = CMD_FADE;
                    case ($urandom_range(0, 9))
                        0: it.fade_target = TARGET_NONE;
                        1: it.fade_target = TARGET_W'($urandom());
                        2: it.fade_target = TARGET_W'(level_now);
                        3: it.fade_target = $urandom_range(0, 1) ? 18'sd65536 : 18'sd0;
                        default: it.fade_target = TARGET_W'($urandom_range(0, 65536));
                    endcase
                    case ($urandom_range(0, 9))
                        0: it.fade_time = '0;
                        1: it.fade_time = TIME_W'($urandom());
                        2, 3: it.fade_time = TIME_W'($urandom_range(65, 2000));
                        default: it.fade_time = TIME_W'($urandom_range(1, 64));
                    endcase
                    send_cmd(it);
                    send_ticks($urandom_range(2, 12));
                end else if (kind < 65) begin
                    it     = noise_item();
                    it.cmd = CMD_RESET;
                    send_cmd(it);
                    send_ticks($urandom_range(2, 10));
                end else if (kind < 80) begin
                    send_ticks($urandom_range(1, 4));
                end else if (kind < 92) begin
                    it     = noise_item();
                    it.cmd = $urandom_range(0, 1) ? CMD_ATTACH : CMD_SET_ALPHA;
                    send_cmd(it);
                end else begin
                    send_cmd(noise_item());
                end
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // The result side stalls while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        t_ramp_cmd it;
        wait_drain();
        no_idle = 1'b1;
        hold_requests++;
        it           = noise_item();
        it.cmd       = CMD_FADE;
        it.fade_target = 18'sd0;
        it.fade_time = 16'd16;
        send_cmd(it);
        send_ticks(24);
        it           = noise_item();
        it.cmd       = CMD_SET_ALPHA;
        send_cmd(it);
        wait_drain();
        no_idle = 1'b0;
    endtask

    initial begin : result_sink
        int idle_left;
        int hold_left;
        int holds_done;
        idle_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                res_bus.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                idle_left = pick_gap() - 1;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_ramp_result want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_levels.size() == 0) begin
                flag_error($sformatf("result with none pending: level %0d animating %0b",
                                     res_bus.level, res_bus.animating));
            end else begin
                want = expected_levels.pop_front();
                if (res_bus.level !== want.level) begin
                    flag_error($sformatf("level expected %0d actual %0d",
                                         want.level, res_bus.level));
                end
                if (res_bus.animating !== want.animating) begin
                    flag_error($sformatf("animating expected %0b actual %0b",
                                         want.animating, res_bus.animating));
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        items_sent    = 0;
        error_count   = 0;
        hold_requests = 0;
        no_idle       = 1'b0;
        start_speed   = '0;
        start_accel   = '0;
        start_delay   = '0;
        start_target  = TARGET_NONE;
        restore_now   = 1'b0;
        level_now     = '0;
        speed_now     = '0;
        accel_now     = '0;
        delay_now     = '0;
        tgt_now       = TARGET_NONE;
        saved_now     = '0;
        saved_ok      = 1'b0;

        rst_n               <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.cmd         <= '0;
        cmd_bus.step        <= '0;
        cmd_bus.fade_target <= '0;
        cmd_bus.fade_time   <= '0;
        cmd_bus.new_alpha   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_level_commands();
        test_fade_commands();
        test_start_values();
        test_random_ramps();
        test_backpressure();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_levels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
